// ----- hdl/rtw_pkg.sv -----
package rtw_pkg;

   // Default sizes of the node pool and of a stored value.
   localparam int NODE_COUNT_DEFAULT  = 256;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Fixed geometry of the tree: four levels of 16-slot nodes over a 16-bit key.
   localparam int KEY_W          = 16;
   localparam int NIBBLE_W       = 4;
   localparam int SLOTS_PER_NODE = 16;
   localparam int LEVEL_W        = 2;
   localparam int IN_VALUE_W     = 32;
   localparam int OUT_VALUE_W    = 32;
   localparam int STATUS_W       = 3;

   localparam logic [LEVEL_W-1:0]  LAST_LEVEL = 2'd3;
   localparam logic [NIBBLE_W-1:0] LAST_SLOT  = 4'hF;

   // Operation codes on the request channel.
   typedef enum logic [1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_REMOVE = 2'd1,
      FUNC_FIND   = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   // Status codes on the response channel.
   typedef enum logic [STATUS_W-1:0] {
      STATUS_DONE       = 3'd0,
      STATUS_ZERO_VALUE = 3'd1,
      STATUS_NO_NODES   = 3'd2,
      STATUS_PRESENT    = 3'd3,
      STATUS_ABSENT     = 3'd4
   } status_type;

   // Selects the key nibble used at a level, high nibble at the root.
   function automatic logic [NIBBLE_W-1:0] key_nibble(input logic [KEY_W-1:0] key,
                                                      input logic [LEVEL_W-1:0] level);
      logic [NIBBLE_W-1:0] nib;
      case (level)
         2'd0: begin
            nib = key[15:12];
         end
         2'd1: begin
            nib = key[11:8];
         end
         2'd2: begin
            nib = key[7:4];
         end
         default: begin
            nib = key[3:0];
         end
      endcase
      return nib;
   endfunction

endpackage

// ----- hdl/rtw_slot_ram.sv -----
module rtw_slot_ram #(
   parameter int NODE_COUNT = rtw_pkg::NODE_COUNT_DEFAULT,
   parameter int SLOT_W     = rtw_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               wr_en,
   input  logic [$clog2(NODE_COUNT)+rtw_pkg::NIBBLE_W-1:0]    wr_addr,
   input  logic [SLOT_W-1:0]                                  wr_data,
   input  logic [$clog2(NODE_COUNT)+rtw_pkg::NIBBLE_W-1:0]    rd_addr,
   output logic [SLOT_W-1:0]                                  rd_data
);

   localparam int DEPTH = NODE_COUNT * rtw_pkg::SLOTS_PER_NODE;

   logic [SLOT_W-1:0] mem [DEPTH];
   logic [SLOT_W-1:0] rd_data_ff;

   // One write port and one read port with registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hdl/radix_table_walker_unit.sv -----
// Radix table walker: a map from a 16-bit key to a nonzero value, held as a four-level
// tree of 16-slot nodes in one slot memory with a registered read. A request is taken
// when start is high and busy is low; its single response appears on the rsp_ ports for
// exactly one cycle, flagged by rsp_strobe, and the receiver cannot stall it. The walk
// reads one slot per level; a missing path ends the walk early, and an insert of zero
// answers in the next cycle. Each node that an insert creates is linked, then its 16
// slots are zeroed through the single write port, one write per slot, and the slot is
// read anew before the walk goes on. A clear zeroes the root the same way and then
// answers. After reset the root is zeroed, with busy high and no response.
module radix_table_walker_unit #(
   parameter int NODE_COUNT  = rtw_pkg::NODE_COUNT_DEFAULT,
   parameter int VALUE_WIDTH = rtw_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [1:0]                         req_func,
   input  logic [rtw_pkg::KEY_W-1:0]          req_key,
   input  logic [rtw_pkg::IN_VALUE_W-1:0]     req_value,
   output logic                               rsp_strobe,
   output logic [rtw_pkg::STATUS_W-1:0]       rsp_status,
   output logic [rtw_pkg::OUT_VALUE_W-1:0]    rsp_value_out
);

   localparam int NODE_BITS = $clog2(NODE_COUNT);
   localparam int ADDR_W    = NODE_BITS + rtw_pkg::NIBBLE_W;
   localparam int CNT_W     = $clog2(NODE_COUNT + 1);
   // A slot holds either a value or a child index.
   localparam int SLOT_W    = (VALUE_WIDTH > NODE_BITS) ? VALUE_WIDTH : NODE_BITS;
   localparam int WIDE_W    = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;
   localparam logic [rtw_pkg::IN_VALUE_W-1:0] IN_MASK =
      (VALUE_WIDTH >= rtw_pkg::IN_VALUE_W) ? '1 :
      rtw_pkg::IN_VALUE_W'((64'd1 << VALUE_WIDTH) - 64'd1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_ZERO,
      ST_LOOKUP
   } state_type;

   // Where the zeroing sweep goes when it is done.
   typedef enum logic [1:0] {
      ZR_IDLE,
      ZR_RESP,
      ZR_WALK
   } zero_ret_type;

   state_type                          state_ff, state_in;
   zero_ret_type                       zero_ret_ff, zero_ret_in;
   rtw_pkg::func_type                  func_ff, func_in;
   logic [rtw_pkg::KEY_W-1:0]          key_ff, key_in;
   logic [SLOT_W-1:0]                  val_ff, val_in;
   logic [rtw_pkg::LEVEL_W-1:0]        level_ff, level_in;
   logic [NODE_BITS-1:0]               node_ff, node_in;
   logic [CNT_W-1:0]                   nodes_used_ff, nodes_used_in;
   logic [rtw_pkg::NIBBLE_W-1:0]       zero_cnt_ff, zero_cnt_in;
   logic                               rsp_strobe_ff, rsp_strobe_in;
   logic [rtw_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [rtw_pkg::OUT_VALUE_W-1:0]    rsp_value_ff, rsp_value_in;

   logic                               mem_we;
   logic [ADDR_W-1:0]                  mem_waddr;
   logic [SLOT_W-1:0]                  mem_wdata;
   logic [ADDR_W-1:0]                  mem_raddr;
   logic [SLOT_W-1:0]                  mem_rdata;

   logic [rtw_pkg::IN_VALUE_W-1:0]     req_value_masked;
   logic [WIDE_W-1:0]                  child_wide;
   logic                               child_empty;
   logic [NODE_BITS-1:0]               child_node;
   logic [NODE_BITS-1:0]               alloc_node;
   logic                               pool_full;
   logic [rtw_pkg::LEVEL_W-1:0]        level_next;

   rtw_slot_ram #(
      .NODE_COUNT (NODE_COUNT),
      .SLOT_W     (SLOT_W)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // Decode of the slot just read and of the allocator.
   assign req_value_masked = req_value & IN_MASK;
   assign child_wide       = WIDE_W'(mem_rdata);
   assign child_empty      = (child_wide == '0) || (child_wide >= WIDE_W'(NODE_COUNT));
   assign child_node       = mem_rdata[NODE_BITS-1:0];
   assign alloc_node       = nodes_used_ff[NODE_BITS-1:0];
   assign pool_full        = (nodes_used_ff >= CNT_W'(NODE_COUNT));
   assign level_next       = rtw_pkg::LEVEL_W'(level_ff + 1'b1);

   // Next-state logic of the walk, the allocator and the zeroing sweep.
   always_comb begin
      state_in      = state_ff;
      zero_ret_in   = zero_ret_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      val_in        = val_ff;
      level_in      = level_ff;
      node_in       = node_ff;
      nodes_used_in = nodes_used_ff;
      zero_cnt_in   = zero_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;
      mem_waddr     = {node_ff, zero_cnt_ff};
      mem_wdata     = '0;
      mem_raddr     = {node_ff, rtw_pkg::key_nibble(key_ff, level_ff)};

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               func_in  = rtw_pkg::func_type'(req_func);
               key_in   = req_key;
               val_in   = SLOT_W'(req_value_masked);
               level_in = '0;
               node_in  = '0;
               if (req_func == rtw_pkg::FUNC_CLEAR) begin
                  nodes_used_in = CNT_W'(1);
                  zero_cnt_in   = '0;
                  zero_ret_in   = ZR_RESP;
                  state_in      = ST_ZERO;
               end else if ((req_func == rtw_pkg::FUNC_INSERT) &&
                            (req_value_masked == '0)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = rtw_pkg::STATUS_ZERO_VALUE;
                  rsp_value_in  = '0;
               end else begin
                  mem_raddr = {NODE_BITS'(0), rtw_pkg::key_nibble(req_key, '0)};
                  state_in  = ST_WALK;
               end
            end
         end

         ST_WALK: begin
            if (level_ff != rtw_pkg::LAST_LEVEL) begin
               // Inner level: the slot holds a child index.
               if (!child_empty) begin
                  node_in   = child_node;
                  level_in  = level_next;
                  mem_raddr = {child_node, rtw_pkg::key_nibble(key_ff, level_next)};
               end else if (func_ff != rtw_pkg::FUNC_INSERT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = rtw_pkg::STATUS_ABSENT;
                  rsp_value_in  = '0;
                  state_in      = ST_IDLE;
               end else if (pool_full) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = rtw_pkg::STATUS_NO_NODES;
                  rsp_value_in  = '0;
                  state_in      = ST_IDLE;
               end else begin
                  // Link a fresh node, then zero it before walking on.
                  mem_we        = 1'b1;
                  mem_waddr     = {node_ff, rtw_pkg::key_nibble(key_ff, level_ff)};
                  mem_wdata     = SLOT_W'(alloc_node);
                  node_in       = alloc_node;
                  nodes_used_in = CNT_W'(nodes_used_ff + 1'b1);
                  level_in      = level_next;
                  zero_cnt_in   = '0;
                  zero_ret_in   = ZR_WALK;
                  state_in      = ST_ZERO;
               end
            end else begin
               // Leaf level: the slot holds the stored value.
               mem_waddr     = {node_ff, rtw_pkg::key_nibble(key_ff, level_ff)};
               rsp_strobe_in = 1'b1;
               rsp_value_in  = '0;
               state_in      = ST_IDLE;
               if (func_ff == rtw_pkg::FUNC_INSERT) begin
                  if (mem_rdata != '0) begin
                     rsp_status_in = rtw_pkg::STATUS_PRESENT;
                  end else begin
                     rsp_status_in = rtw_pkg::STATUS_DONE;
                     mem_we        = 1'b1;
                     mem_wdata     = val_ff;
                  end
               end else if (mem_rdata == '0) begin
                  rsp_status_in = rtw_pkg::STATUS_ABSENT;
               end else begin
                  rsp_status_in = rtw_pkg::STATUS_DONE;
                  rsp_value_in  = rtw_pkg::OUT_VALUE_W'(mem_rdata);
                  if (func_ff == rtw_pkg::FUNC_REMOVE) begin
                     mem_we    = 1'b1;
                     mem_wdata = '0;
                  end
               end
            end
         end

         ST_ZERO: begin
            mem_we      = 1'b1;
            zero_cnt_in = rtw_pkg::NIBBLE_W'(zero_cnt_ff + 1'b1);
            if (zero_cnt_ff == rtw_pkg::LAST_SLOT) begin
               case (zero_ret_ff)
                  ZR_RESP: begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = rtw_pkg::STATUS_DONE;
                     rsp_value_in  = '0;
                     state_in      = ST_IDLE;
                  end
                  ZR_WALK: begin
                     state_in = ST_LOOKUP;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_LOOKUP: begin
            // The read of the new node's slot is issued here.
            state_in = ST_WALK;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered response; reset zeroes the root before the first request.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_ZERO;
         zero_ret_ff   <= ZR_IDLE;
         node_ff       <= '0;
         zero_cnt_ff   <= '0;
         nodes_used_ff <= CNT_W'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         zero_ret_ff   <= zero_ret_in;
         node_ff       <= node_in;
         zero_cnt_ff   <= zero_cnt_in;
         nodes_used_ff <= nodes_used_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      func_ff       <= func_in;
      key_ff        <= key_in;
      val_ff        <= val_in;
      level_ff      <= level_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = rsp_strobe_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_value_out = rsp_value_ff;

`ifndef NO_ASSERTIONS
   // A response always leaves the unit ready for the next transfer.
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while the walk is still busy");

   // The pool count never drops below the root nor passes the pool size.
   a_pool_range: assert property (@(posedge clock) disable iff (reset)
      (nodes_used_ff != '0) && (nodes_used_ff <= CNT_W'(NODE_COUNT)))
      else $error("node pool count out of range");

   // An insert of a zero value is rejected in the next cycle.
   a_zero_insert: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_func == rtw_pkg::FUNC_INSERT) && (req_value_masked == '0))
      |=> (rsp_strobe && (rsp_status == rtw_pkg::STATUS_ZERO_VALUE)))
      else $error("zero-value insert not rejected at once");

   // Only a successful find or remove carries a value.
   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status != rtw_pkg::STATUS_DONE)) |-> (rsp_value_out == '0))
      else $error("value returned with a failure status");
`endif

endmodule

// ----- verif/tb_radix_table_walker_unit.sv -----
`timescale 1ns / 100ps

module tb_radix_table_walker_unit;

   localparam int POOL_NODES = rtw_pkg::NODE_COUNT_DEFAULT;
   localparam int SLOT_TOTAL = POOL_NODES * rtw_pkg::SLOTS_PER_NODE;
   localparam int RANDOM_ITEMS = 1600;
   localparam int DIRECTED_ROWS = 24;

   // One row of the directed script; the typed response is used when known is set.
   typedef struct {
      rtw_pkg::func_type          func;
      logic [rtw_pkg::KEY_W-1:0]  key;
      logic [31:0]                value;
      bit                         known;
      rtw_pkg::status_type        status;
      logic [31:0]                result;
   } script_row_type;

   // One awaited response.
   typedef struct {
      rtw_pkg::status_type        status;
      logic [31:0]                result;
   } trie_reply_type;

   logic                                clock = 1'b0;
   logic                                reset = 1'b1;
   logic                                start = 1'b0;
   logic                                busy;
   logic [1:0]                          req_func = rtw_pkg::FUNC_INSERT;
   logic [rtw_pkg::KEY_W-1:0]           req_key = '0;
   logic [rtw_pkg::IN_VALUE_W-1:0]      req_value = '0;
   logic                                rsp_strobe;
   logic [rtw_pkg::STATUS_W-1:0]        rsp_status;
   logic [rtw_pkg::OUT_VALUE_W-1:0]     rsp_value_out;

   // Shadow copy of the trie: slot memory and the bump allocator.
   logic [31:0]              shadow_slots [SLOT_TOTAL];
   int unsigned              nodes_taken;

   trie_reply_type           awaited_rsp [$];
   int                       error_count = 0;
   int                       items_issued = 0;
   int                       rsp_checked = 0;
   int                       status_seen [5];
   int                       idle_pct = 31;

   radix_table_walker_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_func      (req_func),
      .req_key       (req_key),
      .req_value     (req_value),
      .rsp_strobe    (rsp_strobe),
      .rsp_status    (rsp_status),
      .rsp_value_out (rsp_value_out)
   );

   // Free-running 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Nibble of the key that indexes the node at a given level, root level first.
   function automatic int unsigned level_slot(input logic [rtw_pkg::KEY_W-1:0] key,
                                              input int unsigned lvl);
      logic [rtw_pkg::KEY_W-1:0] shifted;
      shifted = key >> (4 * (3 - lvl));
      return int'(shifted[3:0]);
   endfunction

   // Follows the key down to its leaf slot, growing missing nodes when asked to.
   function automatic rtw_pkg::status_type descend(input logic [rtw_pkg::KEY_W-1:0] key,
                                                   input bit grow,
                                                   output int unsigned leaf);
      int unsigned node;
      int unsigned at;
      logic [31:0] child;
      node = 0;
      leaf = 0;
      for (int unsigned lvl = 0; lvl < 3; lvl++) begin
         at = node * rtw_pkg::SLOTS_PER_NODE + level_slot(key, lvl);
         child = shadow_slots[at];
         if (child == 0 || child >= POOL_NODES) begin
            if (!grow) begin
               return rtw_pkg::STATUS_ABSENT;
            end
            if (nodes_taken >= POOL_NODES) begin
               return rtw_pkg::STATUS_NO_NODES;
            end
            child = nodes_taken;
            nodes_taken++;
            for (int s = 0; s < rtw_pkg::SLOTS_PER_NODE; s++) begin
               shadow_slots[child * rtw_pkg::SLOTS_PER_NODE + s] = '0;
            end
            shadow_slots[at] = child;
         end
         node = child;
      end
      leaf = node * rtw_pkg::SLOTS_PER_NODE + level_slot(key, 3);
      return rtw_pkg::STATUS_DONE;
   endfunction

   // Applies one request to the shadow trie and returns the response it must produce.
   function automatic trie_reply_type trie_apply(input rtw_pkg::func_type func,
                                                 input logic [rtw_pkg::KEY_W-1:0] key,
                                                 input logic [31:0] value);
      trie_reply_type reply;
      int unsigned leaf;
      rtw_pkg::status_type walk_status;
      reply.status = rtw_pkg::STATUS_DONE;
      reply.result = '0;
      case (func)
         rtw_pkg::FUNC_CLEAR: begin
            for (int s = 0; s < rtw_pkg::SLOTS_PER_NODE; s++) begin
               shadow_slots[s] = '0;
            end
            nodes_taken = 1;
         end
         rtw_pkg::FUNC_INSERT: begin
            if (value == 0) begin
               reply.status = rtw_pkg::STATUS_ZERO_VALUE;
            end else begin
               walk_status = descend(key, 1'b1, leaf);
               if (walk_status != rtw_pkg::STATUS_DONE) begin
                  reply.status = walk_status;
               end else if (shadow_slots[leaf] != 0) begin
                  reply.status = rtw_pkg::STATUS_PRESENT;
               end else begin
                  shadow_slots[leaf] = value;
               end
            end
         end
         default: begin
            walk_status = descend(key, 1'b0, leaf);
            if (walk_status != rtw_pkg::STATUS_DONE || shadow_slots[leaf] == 0) begin
               reply.status = rtw_pkg::STATUS_ABSENT;
            end else begin
               reply.result = shadow_slots[leaf];
               if (func == rtw_pkg::FUNC_REMOVE) begin
                  shadow_slots[leaf] = '0;
               end
            end
         end
      endcase
      return reply;
   endfunction

   // Random payload with the extremes mixed in.
   function automatic logic [31:0] pick_value();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 8) begin
         return '0;
      end else if (r < 13) begin
         return '1;
      end
      return $urandom;
   endfunction

   // Presents one request, waits for its transfer and records the awaited response.
   task automatic issue_request(input rtw_pkg::func_type func,
                                input logic [rtw_pkg::KEY_W-1:0] key,
                                input logic [31:0] value, input bit known,
                                input rtw_pkg::status_type known_status,
                                input logic [31:0] known_result,
                                output rtw_pkg::status_type predicted);
      trie_reply_type reply;
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start     <= 1'b1;
      req_func  <= func;
      req_key   <= key;
      req_value <= value;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      reply = trie_apply(func, key, value);
      predicted = reply.status;
      if (known) begin
         reply.status = known_status;
         reply.result = known_result;
      end
      awaited_rsp.push_back(reply);
      items_issued++;
      if (items_issued == RANDOM_ITEMS / 3) begin
         idle_pct = 54;
      end else if (items_issued == 2 * RANDOM_ITEMS / 3) begin
         idle_pct = 0;
      end
   endtask

   // Shorthand for a request whose response comes from the shadow trie.
   task automatic issue_checked(input rtw_pkg::func_type func,
                                input logic [rtw_pkg::KEY_W-1:0] key,
                                input logic [31:0] value,
                                output rtw_pkg::status_type predicted);
      issue_request(func, key, value, 1'b0, rtw_pkg::STATUS_DONE, '0, predicted);
   endtask

   // Each response strobe is compared with the oldest awaited response.
   always @(posedge clock) begin
      trie_reply_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsp.size() == 0) begin
            $display("%0t: unexpected response, expected none, got status %0d value %h",
                     $time, rsp_status, rsp_value_out);
            error_count++;
         end else begin
            want = awaited_rsp.pop_front();
            rsp_checked++;
            if (rsp_status <= rtw_pkg::STATUS_ABSENT) begin
               status_seen[rsp_status]++;
            end
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, got %0d",
                        $time, want.status, rsp_status);
               error_count++;
            end
            if (rsp_value_out !== want.result) begin
               $display("%0t: value_out mismatch, expected %h, got %h",
                        $time, want.result, rsp_value_out);
               error_count++;
            end
         end
      end
   end

   // Stimulus: reset, directed script, then randomized episodes.
   initial begin
      script_row_type script [DIRECTED_ROWS];
      logic [rtw_pkg::KEY_W-1:0] work_keys [12];
      logic [rtw_pkg::KEY_W-1:0] filled_keys [$];
      logic [rtw_pkg::KEY_W-1:0] base;
      logic [rtw_pkg::KEY_W-1:0] keep;
      logic [rtw_pkg::KEY_W-1:0] k;
      rtw_pkg::status_type st;
      int unsigned r;
      int no_node_hits;
      int n;

      for (int s = 0; s < SLOT_TOTAL; s++) begin
         shadow_slots[s] = '0;
      end
      nodes_taken = 1;
      foreach (status_seen[i]) begin
         status_seen[i] = 0;
      end

      script = '{
         '{rtw_pkg::FUNC_FIND,   16'h0000, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_REMOVE, 16'h0000, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'h0000, 32'h0, 1'b1, rtw_pkg::STATUS_ZERO_VALUE, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'h0000, 32'hFFFF_FFFF, 1'b1, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'h0000, 32'h1, 1'b1, rtw_pkg::STATUS_PRESENT, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'h0000, 32'h0, 1'b1, rtw_pkg::STATUS_DONE, 32'hFFFF_FFFF},
         '{rtw_pkg::FUNC_INSERT, 16'hFFFF, 32'h1, 1'b1, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'hFFFF, 32'h0, 1'b1, rtw_pkg::STATUS_DONE, 32'h1},
         '{rtw_pkg::FUNC_FIND,   16'hFFF0, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'hF000, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'hFFF0, 32'hDEAD_BEEF, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'hFFF0, 32'h0, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_REMOVE, 16'hFFFF, 32'h0, 1'b1, rtw_pkg::STATUS_DONE, 32'h1},
         '{rtw_pkg::FUNC_REMOVE, 16'hFFFF, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'hFFFF, 32'h8000_0000, 1'b1, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'h5A5A, 32'hA5A5_A5A5, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'hA5A5, 32'h5A5A_5A5A, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'h5A5A, 32'h0, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_CLEAR,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'h0000, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'hFFFF, 32'h0, 1'b1, rtw_pkg::STATUS_ABSENT, 32'h0},
         '{rtw_pkg::FUNC_INSERT, 16'h1234, 32'h0000_FFFF, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_FIND,   16'h1234, 32'h0, 1'b0, rtw_pkg::STATUS_DONE, 32'h0},
         '{rtw_pkg::FUNC_CLEAR,  16'h0000, 32'h0, 1'b1, rtw_pkg::STATUS_DONE, 32'h0}
      };

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed part: extremes, every operation and the found and missing paths of the walk.
      foreach (script[i]) begin
         issue_request(script[i].func, script[i].key, script[i].value, script[i].known,
                       script[i].status, script[i].result, st);
      end

      // Random part, in episodes. Most reuse a small set of related keys so that
      // inserts, finds and removes meet; some fill the pool until it runs dry.
      while (items_issued < RANDOM_ITEMS + DIRECTED_ROWS) begin
         if ($urandom_range(99) < 15) begin
            issue_checked(rtw_pkg::FUNC_CLEAR, 16'($urandom), $urandom, st);
            filled_keys.delete();
            no_node_hits = 0;
            n = 0;
            while (n < 300 && no_node_hits < 6) begin
               k = 16'($urandom);
               r = $urandom;
               if (r == 0) begin
                  r = 1;
               end
               issue_checked(rtw_pkg::FUNC_INSERT, k, r, st);
               if (st == rtw_pkg::STATUS_DONE) begin
                  filled_keys.push_back(k);
               end else if (st == rtw_pkg::STATUS_NO_NODES) begin
                  no_node_hits++;
               end
               n++;
            end
            repeat (40) begin
               if (filled_keys.size() > 0 && $urandom_range(99) < 80) begin
                  k = filled_keys[$urandom_range(filled_keys.size() - 1)];
               end else begin
                  k = 16'($urandom);
               end
               if ($urandom_range(1) == 1) begin
                  issue_checked(rtw_pkg::FUNC_FIND, k, $urandom, st);
               end else begin
                  issue_checked(rtw_pkg::FUNC_REMOVE, k, $urandom, st);
               end
            end
         end else begin
            if ($urandom_range(1) == 1) begin
               issue_checked(rtw_pkg::FUNC_CLEAR, 16'($urandom), $urandom, st);
            end
            base = 16'($urandom);
            foreach (work_keys[i]) begin
               keep = '0;
               for (int nib = 0; nib < 4; nib++) begin
                  if ($urandom_range(1) == 1) begin
                     keep[nib*4 +: 4] = 4'hF;
                  end
               end
               work_keys[i] = (base & keep) | (16'($urandom) & ~keep);
            end
            repeat (40) begin
               if ($urandom_range(99) < 85) begin
                  k = work_keys[$urandom_range(11)];
               end else begin
                  k = 16'($urandom);
               end
               r = $urandom_range(99);
               if (r < 40) begin
                  issue_checked(rtw_pkg::FUNC_INSERT, k, pick_value(), st);
               end else if (r < 70) begin
                  issue_checked(rtw_pkg::FUNC_FIND, k, $urandom, st);
               end else if (r < 97) begin
                  issue_checked(rtw_pkg::FUNC_REMOVE, k, $urandom, st);
               end else begin
                  issue_checked(rtw_pkg::FUNC_CLEAR, k, $urandom, st);
               end
            end
         end
      end
      start <= 1'b0;

      // Drain the outstanding responses, then watch for stray strobes a while.
      while (awaited_rsp.size() != 0) begin
         @(posedge clock);
      end
      repeat (60) @(posedge clock);

      $display("Issued %0d requests, checked %0d responses.", items_issued, rsp_checked);
      $display("Status counts: done %0d, zero value %0d, out of nodes %0d, present %0d,",
               status_seen[rtw_pkg::STATUS_DONE], status_seen[rtw_pkg::STATUS_ZERO_VALUE],
               status_seen[rtw_pkg::STATUS_NO_NODES], status_seen[rtw_pkg::STATUS_PRESENT]);
      $display("absent %0d.", status_seen[rtw_pkg::STATUS_ABSENT]);
      if (error_count == 0 && awaited_rsp.size() == 0) begin
         $display("** radix_table_walker_unit: PASSED **");
      end else begin
         $display("** radix_table_walker_unit: FAILED **");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #2000000;
      $display("%0t: timeout with %0d responses outstanding", $time, awaited_rsp.size());
      $display("** radix_table_walker_unit: FAILED **");
      $finish;
   end

endmodule
